FILE: rtl/bounded_doubly_linked_list_assert.svh
// Assertion macros for the bounded doubly linked list.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDLL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bdll_pkg.sv
// Shared constants, codes and control/status types of the linked list block.
// No dependencies.
package bdll_pkg;
	localparam int CAPACITY   = 256;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int POS_W      = 9;
	localparam int GRP_SIZE   = 16;
	localparam int GRP_W      = $clog2(GRP_SIZE);
	localparam int NGRP       = CAPACITY / GRP_SIZE;
	localparam int NGRP_W     = SLOT_W - GRP_W;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 56;

	// Operation codes
	localparam logic [2:0] OP_INSERT       = 3'd0;
	localparam logic [2:0] OP_REMOVE       = 3'd1;
	localparam logic [2:0] OP_READ         = 3'd2;
	localparam logic [2:0] OP_SEARCH       = 3'd3;
	localparam logic [2:0] OP_REMOVE_MATCH = 3'd4;
	localparam logic [2:0] OP_CLEAR        = 3'd5;

	// Datapath commands
	localparam logic [3:0] C_NOP     = 4'd0;
	localparam logic [3:0] C_LATCH   = 4'd1;
	localparam logic [3:0] C_CLEAR   = 4'd2;
	localparam logic [3:0] C_FREE1   = 4'd3;
	localparam logic [3:0] C_FREE2   = 4'd4;
	localparam logic [3:0] C_START   = 4'd5;
	localparam logic [3:0] C_STEP    = 4'd6;
	localparam logic [3:0] C_W_EMPTY = 4'd7;
	localparam logic [3:0] C_W_TAIL1 = 4'd8;
	localparam logic [3:0] C_W_TAIL2 = 4'd9;
	localparam logic [3:0] C_W_MID1  = 4'd10;
	localparam logic [3:0] C_W_MID2  = 4'd11;
	localparam logic [3:0] C_UNLINK  = 4'd12;
	localparam logic [3:0] C_READ    = 4'd13;
	localparam logic [3:0] C_FOUND   = 4'd14;
	localparam logic [3:0] C_LOAD    = 4'd15;

	typedef struct packed {
		logic [3:0] code;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       op;
		logic             pos_gt_count;
		logic             pos_lt_count;
		logic             full;
		logic             empty;
		logic             f_eq_count;
		logic             at_target;
		logic             match;
		logic             last;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} status_t;
endpackage

FILE: rtl/bdll_datapath.sv
// Datapath of the linked list: node store, link memories, walk registers,
// free-slot finder and result registers. Depends on bdll_pkg.
module bdll_datapath import bdll_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  logic [2:0]       in_op,
	input  logic [IN_W-1:0]  in_data,
	output logic             out_tvalid,
	input  logic             out_tready,
	output logic [OUT_W-1:0] out_tdata
);
	logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
	logic [SLOT_W-1:0]     next_mem [CAPACITY];
	logic [SLOT_W-1:0]     prev_mem [CAPACITY];

	logic [2:0]            op_q;
	logic [POS_W-1:0]      pos_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  dir_q;
	logic [CAPACITY-1:0]   in_use_q;
	logic [SLOT_W-1:0]     front_q, back_q, cur_q, free_q;
	logic [CNT_W-1:0]      count_q, idx_q;
	logic [NGRP-1:0]       grp_any_q;
	logic [GRP_W-1:0]      grp_idx_q [NGRP];
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [SLOT_W-1:0]     rd_next_q, rd_prev_q;
	logic                  res_ok_q;
	logic [VALUE_BITS-1:0] res_rv_q;
	logic [POS_W-1:0]      res_fi_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic                  walk_dir, rd_en;
	logic [SLOT_W-1:0]     start_slot, link, rd_addr;
	logic [CNT_W-1:0]      f_pos, tgt;
	logic                  v_we, n_we, p_we;
	logic [SLOT_W-1:0]     v_addr, n_addr, p_addr, n_data, p_data;
	logic [NGRP-1:0]       grp_any_d;
	logic [GRP_W-1:0]      grp_idx_d [NGRP];
	logic [NGRP_W-1:0]     grp_sel;

	// Walk addressing: inserts always count from the front
	assign walk_dir   = (op_q == OP_INSERT) ? 1'b0 : dir_q;
	assign start_slot = walk_dir ? back_q : front_q;
	assign link       = walk_dir ? rd_prev_q : rd_next_q;
	assign rd_en      = (cmd.code == C_START) || (cmd.code == C_STEP);
	assign rd_addr    = (cmd.code == C_START) ? start_slot : link;
	assign f_pos      = dir_q ? (count_q - pos_q) : pos_q;
	assign tgt        = (op_q == OP_INSERT) ? f_pos : pos_q;

	// Status toward the controller
	assign status.op           = op_q;
	assign status.pos_gt_count = pos_q > count_q;
	assign status.pos_lt_count = pos_q < count_q;
	assign status.full         = count_q == CNT_W'(CAPACITY);
	assign status.empty        = count_q == '0;
	assign status.f_eq_count   = f_pos == count_q;
	assign status.at_target    = idx_q == tgt;
	assign status.match        = rd_val_q == val_q;
	assign status.last         = idx_q == (count_q - CNT_W'(1));
	assign status.out_free     = !out_valid_q || out_tready;
	assign status.count        = count_q;

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;

	// Per-group lowest free slot
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_d[g] = ~&in_use_q[g*GRP_SIZE +: GRP_SIZE];
			grp_idx_d[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (!in_use_q[g*GRP_SIZE + b]) grp_idx_d[g] = GRP_W'(b);
			end
		end
	end

	// Lowest group that has a free slot
	always_comb begin
		grp_sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) grp_sel = NGRP_W'(g);
		end
	end

	// Memory write ports per command
	always_comb begin
		v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
		v_addr = free_q; n_addr = free_q; p_addr = free_q;
		n_data = free_q; p_data = free_q;
		unique case (cmd.code)
			C_W_EMPTY: begin
				v_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
			end
			C_W_TAIL1: begin
				v_we = 1'b1;
				p_we = 1'b1; p_data = back_q;
				n_we = 1'b1; n_addr = back_q;
			end
			C_W_TAIL2: begin
				n_we = 1'b1;
			end
			C_W_MID1: begin
				v_we = 1'b1;
				n_we = 1'b1; n_data = cur_q;
				p_we = 1'b1; p_addr = cur_q;
			end
			C_W_MID2: begin
				p_we = 1'b1;
				p_data = (cur_q == front_q) ? free_q : rd_prev_q;
				n_we = cur_q != front_q; n_addr = rd_prev_q;
			end
			C_UNLINK: begin
				n_we = cur_q != front_q; n_addr = rd_prev_q; n_data = rd_next_q;
				p_we = cur_q != back_q; p_addr = rd_next_q; p_data = rd_prev_q;
			end
			default: begin
			end
		endcase
	end

	// Node memories
	always_ff @(posedge clk) begin
		if (v_we) val_mem[v_addr] <= val_q;
		if (rd_en) rd_val_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (n_we) next_mem[n_addr] <= n_data;
		if (rd_en) rd_next_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (p_we) prev_mem[p_addr] <= p_data;
		if (rd_en) rd_prev_q <= prev_mem[rd_addr];
	end

	// List control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.code == C_LOAD) out_valid_q <= 1'b1;
			else if (out_tready) out_valid_q <= 1'b0;
			unique case (cmd.code)
				C_CLEAR: begin
					in_use_q <= '0;
					front_q  <= '0;
					back_q   <= '0;
					count_q  <= '0;
				end
				C_W_EMPTY: begin
					front_q          <= free_q;
					back_q           <= free_q;
					in_use_q[free_q] <= 1'b1;
					count_q          <= count_q + CNT_W'(1);
				end
				C_W_TAIL2: begin
					back_q           <= free_q;
					in_use_q[free_q] <= 1'b1;
					count_q          <= count_q + CNT_W'(1);
				end
				C_W_MID2: begin
					if (cur_q == front_q) front_q <= free_q;
					in_use_q[free_q] <= 1'b1;
					count_q          <= count_q + CNT_W'(1);
				end
				C_UNLINK: begin
					if (cur_q == front_q) front_q <= rd_next_q;
					if (cur_q == back_q) back_q <= rd_prev_q;
					in_use_q[cur_q] <= 1'b0;
					count_q         <= count_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Item, walk and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.code)
			C_LATCH: begin
				op_q     <= in_op;
				pos_q    <= in_data[POS_W-1:0];
				val_q    <= in_data[POS_W +: VALUE_BITS];
				dir_q    <= in_data[POS_W + VALUE_BITS];
				res_ok_q <= 1'b0;
				res_rv_q <= '0;
				res_fi_q <= '1;
			end
			C_FREE1: begin
				grp_any_q <= grp_any_d;
				grp_idx_q <= grp_idx_d;
			end
			C_FREE2: free_q <= {grp_sel, grp_idx_q[grp_sel]};
			C_START: begin
				cur_q <= start_slot;
				idx_q <= '0;
			end
			C_STEP: begin
				cur_q <= link;
				idx_q <= idx_q + CNT_W'(1);
			end
			C_READ: begin
				res_rv_q <= rd_val_q;
				res_ok_q <= 1'b1;
			end
			C_FOUND: begin
				res_fi_q <= idx_q;
				res_ok_q <= 1'b1;
			end
			C_CLEAR, C_W_EMPTY, C_W_TAIL2, C_W_MID2, C_UNLINK: res_ok_q <= 1'b1;
			C_LOAD: out_data_q <= {5'd0, count_q, res_fi_q, res_rv_q, res_ok_q};
			default: begin
			end
		endcase
	end
endmodule

FILE: rtl/bdll_ctrl.sv
// Controller of the linked list: sequences decode, free-slot search, walk,
// link updates and result hand-off. Depends on bdll_pkg.
module bdll_ctrl import bdll_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_FREE1  = 4'd2;
	localparam logic [3:0] S_FREE2  = 4'd3;
	localparam logic [3:0] S_PLACE  = 4'd4;
	localparam logic [3:0] S_TAIL2  = 4'd5;
	localparam logic [3:0] S_START  = 4'd6;
	localparam logic [3:0] S_WALK   = 4'd7;
	localparam logic [3:0] S_MID2   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       is_match_op;

	assign in_ready    = state_q == S_IDLE;
	assign is_match_op = (status.op == OP_SEARCH) || (status.op == OP_REMOVE_MATCH);

	// Next state and command
	always_comb begin
		state_d  = state_q;
		cmd.code = C_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = C_LATCH;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				unique case (status.op)
					OP_INSERT: begin
						if (!status.pos_gt_count && !status.full) state_d = S_FREE1;
					end
					OP_REMOVE, OP_READ: begin
						if (status.pos_lt_count) state_d = S_START;
					end
					OP_SEARCH, OP_REMOVE_MATCH: begin
						if (!status.empty) state_d = S_START;
					end
					OP_CLEAR: cmd.code = C_CLEAR;
					default: begin
					end
				endcase
			end
			S_FREE1: begin
				cmd.code = C_FREE1;
				state_d  = S_FREE2;
			end
			S_FREE2: begin
				cmd.code = C_FREE2;
				state_d  = S_PLACE;
			end
			S_PLACE: begin
				priority if (status.empty) begin
					cmd.code = C_W_EMPTY;
					state_d  = S_FIN;
				end else if (status.f_eq_count) begin
					cmd.code = C_W_TAIL1;
					state_d  = S_TAIL2;
				end else begin
					state_d = S_START;
				end
			end
			S_TAIL2: begin
				cmd.code = C_W_TAIL2;
				state_d  = S_FIN;
			end
			S_START: begin
				cmd.code = C_START;
				state_d  = S_WALK;
			end
			S_WALK: begin
				priority if (is_match_op) begin
					priority if (status.match) begin
						cmd.code = (status.op == OP_SEARCH) ? C_FOUND : C_UNLINK;
						state_d  = S_FIN;
					end else if (status.last) begin
						state_d = S_FIN;
					end else begin
						cmd.code = C_STEP;
					end
				end else if (status.at_target) begin
					priority if (status.op == OP_INSERT) begin
						cmd.code = C_W_MID1;
						state_d  = S_MID2;
					end else if (status.op == OP_REMOVE) begin
						cmd.code = C_UNLINK;
						state_d  = S_FIN;
					end else begin
						cmd.code = C_READ;
						state_d  = S_FIN;
					end
				end else begin
					cmd.code = C_STEP;
				end
			end
			S_MID2: begin
				cmd.code = C_W_MID2;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.code = C_LOAD;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/bounded_doubly_linked_list.sv
// Bounded doubly linked list of up to 256 signed 32-bit values, one item in,
// one result out. Items are taken one at a time. A read, remove or search
// walks the node links one memory read per cycle (positions from front or
// back). An insert first runs the lowest-free-slot search in two steps and
// a placement decision; one in the middle then walks the links and ends
// with a second link write. A finished result waits in its output register
// while the next item is taken.
// Depends on bdll_pkg, bdll_ctrl, bdll_datapath and the assertion header.
`include "bounded_doubly_linked_list_assert.svh"

module bounded_doubly_linked_list import bdll_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // position[8:0], value[40:9], direction[41]
	input  logic [2:0]       s_axis_tuser,  // op[2:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // ok[0], read_value[32:1], found_index[41:33],
	                                        // count[50:42]
);
	cmd_t    cmd;
	status_t status;

	bdll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bdll_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_op      (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata)
	);

	`BDLL_ASSERT_NOW(a_count_bound, 1'b1, status.count <= CNT_W'(CAPACITY), "count over capacity")
	`BDLL_ASSERT_NOW(a_load_free, cmd.code == C_LOAD, status.out_free, "result overwritten")
	`BDLL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"item taken while busy")
endmodule
